FILE: rtl/core/eoi_pkg.sv
// Shared types, constants and the CORDIC angle table for the odometry integrator.
// No dependencies; used by every module in rtl/core.
package eoi_pkg;

    localparam int POS_W            = 48;
    localparam int DPT_W            = 16;
    localparam int HEAD_W           = 16;
    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;

    localparam logic [DPT_W-1:0] DPT_RESET = 16'd2941;

    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;
    localparam logic DIR_FWD    = 1'b1;

    typedef struct packed {
        logic              command;
        logic [1:0]        encoder_index;
        logic              direction;
        logic [HEAD_W-1:0] heading;
    } t_eoi_in;

    typedef struct packed {
        logic signed [POS_W-1:0] x_position;
        logic signed [POS_W-1:0] y_position;
    } t_eoi_out;

    typedef struct packed {
        logic edge_step;
        logic capture;
        logic rot_step;
        logic trig_load;
        logic scale_load;
        logic mul_step;
        logic commit;
    } t_eoi_cmd;

    typedef struct packed {
        logic rot_done;
        logic mul_done;
    } t_eoi_sts;

    localparam logic [31:0] ATAN_UNITS [ATAN_DEPTH] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
        logic [4:0] k;
        k = (idx > 5'd23) ? 5'd23 : idx;
        return ATAN_UNITS[k];
    endfunction

endpackage

FILE: rtl/core/eoi_ctrl.sv
// Sequencing state machine for the odometry integrator.
// Depends on eoi_pkg; drives the command struct of eoi_datapath.
module eoi_ctrl
    import eoi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_command,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_eoi_sts i_sts,
    output t_eoi_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_TRIG,
        S_SCALE,
        S_MUL,
        S_ACC
    } t_state;

    t_state   r_state;
    t_state   n_state;
    logic     r_out_valid;
    logic     in_accept;
    logic     out_free;
    t_eoi_cmd cmd;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_command == CMD_UPDATE) begin
                        cmd.capture = 1'b1;
                        n_state     = S_ROT;
                    end else begin
                        cmd.edge_step = 1'b1;
                    end
                end
            end
            S_ROT: begin
                cmd.rot_step = 1'b1;
                if (i_sts.rot_done) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG: begin
                cmd.trig_load = 1'b1;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale_load = 1'b1;
                n_state        = S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (i_sts.mul_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

FILE: rtl/core/eoi_datapath.sv
// Counters, CORDIC rotator, digit-serial scaling multipliers and position accumulators.
// Depends on eoi_pkg; sequenced by eoi_ctrl through t_eoi_cmd and t_eoi_sts.
module eoi_datapath
    import eoi_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_eoi_cmd         i_cmd,
    output t_eoi_sts         o_sts,
    input  logic             i_cfg_valid,
    input  logic [DPT_W-1:0] i_cfg_data,
    input  t_eoi_in          i_in_data,
    output t_eoi_out         o_out_data
);

    localparam int SW       = COUNT_WIDTH + 1;
    localparam int MW       = POS_W + 16;
    localparam int ND       = (MW + 15) / 16;
    localparam int AW       = ND * 16;
    localparam int CORW     = 34;
    localparam int TW       = DPT_W + 17;
    localparam int PW       = TW + 17;
    localparam int STEP_MAX = (CORDIC_STEPS > ND + 1) ? CORDIC_STEPS : ND + 1;
    localparam int SCW      = $clog2(STEP_MAX);

    localparam logic [AW-1:0]          HALF_LSB = AW'(1) << 15;
    localparam logic signed [CORW-1:0] CORDIC_X0 = CORW'(652032874);

    logic [COUNT_WIDTH-1:0]   r_cnt  [4];
    logic [COUNT_WIDTH-1:0]   r_snap [4];
    logic [DPT_W-1:0]         r_dpt;
    logic [POS_W-1:0]         r_x;
    logic [POS_W-1:0]         r_y;
    logic [SCW-1:0]           r_step;
    logic signed [CORW-1:0]   r_cx;
    logic signed [CORW-1:0]   r_cy;
    logic signed [CORW-1:0]   r_cz;
    logic                     r_flip;
    logic signed [15:0]       r_cos;
    logic signed [15:0]       r_sin;
    logic signed [TW-1:0]     r_dc;
    logic signed [TW-1:0]     r_ds;
    logic [AW-1:0]            r_sy;
    logic [AW-1:0]            r_sx;
    logic signed [PW-1:0]     r_py_a;
    logic signed [PW-1:0]     r_py_b;
    logic signed [PW-1:0]     r_px_a;
    logic signed [PW-1:0]     r_px_b;
    logic [AW-1:0]            r_accy;
    logic [AW-1:0]            r_accx;

    logic signed [COUNT_WIDTH-1:0] delta [4];
    logic signed [SW-1:0]          sum_y;
    logic signed [SW-1:0]          sum_x;
    logic [31:0]                   ang;
    logic                          flip;
    logic signed [31:0]            ang_f;
    logic signed [CORW-1:0]        shx;
    logic signed [CORW-1:0]        shy;
    logic signed [CORW-1:0]        atan_s;
    logic signed [CORW-1:0]        fx;
    logic signed [CORW-1:0]        fy;
    logic [15:0]                   dig_y;
    logic [15:0]                   dig_x;
    logic signed [PW-1:0]          py_a;
    logic signed [PW-1:0]          py_b;
    logic signed [PW-1:0]          px_a;
    logic signed [PW-1:0]          px_b;

    function automatic logic signed [15:0] to_q15(input logic signed [CORW-1:0] v);
        logic signed [CORW-1:0] r;
        r = (v + CORW'(2**14)) >>> 15;
        if (r > CORW'(32767)) begin
            return 16'sh7FFF;
        end else if (r < -CORW'(32768)) begin
            return 16'sh8000;
        end else begin
            return r[15:0];
        end
    endfunction

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            delta[k] = r_cnt[k] - r_snap[k];
        end
        sum_y  = SW'(delta[0]) + SW'(delta[1]);
        sum_x  = SW'(delta[2]) + SW'(delta[3]);
        ang    = {i_in_data.heading, 16'h0000};
        flip   = ang[31] ^ ang[30];
        ang_f  = {ang[31] ^ flip, ang[30:0]};
        shx    = r_cy >>> r_step;
        shy    = r_cx >>> r_step;
        atan_s = signed'(CORW'(atan_lookup(5'(r_step))));
        fx     = r_flip ? -r_cx : r_cx;
        fy     = r_flip ? -r_cy : r_cy;
        dig_y  = r_sy[AW-1 -: 16];
        dig_x  = r_sx[AW-1 -: 16];
        py_a   = signed'({1'b0, dig_y}) * r_dc;
        py_b   = signed'({1'b0, dig_x}) * r_ds;
        px_a   = signed'({1'b0, dig_y}) * r_ds;
        px_b   = signed'({1'b0, dig_x}) * r_dc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k]  <= '0;
                r_snap[k] <= '0;
            end
            r_dpt <= DPT_RESET;
            r_x   <= '0;
            r_y   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_dpt <= i_cfg_data;
            end
            if (i_cmd.edge_step) begin
                if (i_in_data.direction == DIR_FWD) begin
                    r_cnt[i_in_data.encoder_index] <=
                        r_cnt[i_in_data.encoder_index] + COUNT_WIDTH'(1);
                end else begin
                    r_cnt[i_in_data.encoder_index] <=
                        r_cnt[i_in_data.encoder_index] - COUNT_WIDTH'(1);
                end
            end
            if (i_cmd.capture) begin
                for (int k = 0; k < 4; k++) begin
                    r_snap[k] <= r_cnt[k];
                end
            end
            if (i_cmd.commit) begin
                r_y <= r_y + POS_W'((r_accy + HALF_LSB) >> 16);
                r_x <= r_x + POS_W'((r_accx + HALF_LSB) >> 16);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sy   <= AW'(sum_y);
            r_sx   <= AW'(sum_x);
            r_cx   <= CORDIC_X0;
            r_cy   <= '0;
            r_cz   <= CORW'(ang_f);
            r_flip <= flip;
            r_step <= '0;
        end
        if (i_cmd.rot_step) begin
            if (r_cz < 0) begin
                r_cx <= r_cx + shx;
                r_cy <= r_cy - shy;
                r_cz <= r_cz + atan_s;
            end else begin
                r_cx <= r_cx - shx;
                r_cy <= r_cy + shy;
                r_cz <= r_cz - atan_s;
            end
            r_step <= r_step + SCW'(1);
        end
        if (i_cmd.trig_load) begin
            r_cos <= to_q15(fx);
            r_sin <= to_q15(fy);
        end
        if (i_cmd.scale_load) begin
            r_dc   <= signed'({1'b0, r_dpt}) * r_cos;
            r_ds   <= signed'({1'b0, r_dpt}) * r_sin;
            r_accy <= '0;
            r_accx <= '0;
            r_py_a <= '0;
            r_py_b <= '0;
            r_px_a <= '0;
            r_px_b <= '0;
            r_step <= '0;
        end
        if (i_cmd.mul_step) begin
            r_py_a <= py_a;
            r_py_b <= py_b;
            r_px_a <= px_a;
            r_px_b <= px_b;
            r_accy <= (r_accy << 16) + AW'(r_py_a) + AW'(r_py_b);
            r_accx <= (r_accx << 16) + AW'(r_px_a) + AW'(r_px_b);
            r_sy   <= r_sy << 16;
            r_sx   <= r_sx << 16;
            r_step <= r_step + SCW'(1);
        end
    end

    assign o_sts.rot_done        = (r_step == SCW'(CORDIC_STEPS - 1));
    assign o_sts.mul_done        = (r_step == SCW'(ND));
    assign o_out_data.x_position = r_x;
    assign o_out_data.y_position = r_y;

endmodule

FILE: rtl/core/encoder_odometry_integrator_unit.sv
// Top level of the wheel-encoder odometry integrator: controller plus datapath.
// Depends on eoi_pkg, eoi_ctrl and eoi_datapath.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     t_eoi_in  (edge or update request)
//   out       output     o_out_valid / i_out_ready   t_eoi_out (X and Y position)
//   cfg       input      i_cfg_valid / o_cfg_ready   distance per tick, 16 bits
//
// An edge request produces no result, and the block stays ready for the next request.
// An update request occupies the block through the rotate, trig, scale, multiply and accumulate
// states before the next request can be taken; by default the CORDIC iteration loop is the longest.
// A finished position waits in the output register; the block keeps taking edge requests,
// and a further update stalls only at its final accumulate step until the output is taken.
// Synchronous reset clears the counters and positions and restores the default distance.
module encoder_odometry_integrator_unit
    import eoi_pkg::*;
#(
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_eoi_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_eoi_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [DPT_W-1:0] i_cfg_data
);

    t_eoi_cmd cmd;
    t_eoi_sts sts;

    assign o_cfg_ready = 1'b1;

    eoi_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_command (i_in_data.command),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    eoi_datapath #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data)
    );

    a_edge_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.command == CMD_EDGE && !o_out_valid)
        |=> !o_out_valid)
        else $error("edge request produced a result");

    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.command == CMD_UPDATE) |=> !o_in_ready)
        else $error("update request did not occupy the block");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without an update in progress");

endmodule
